FILE: src/bgts_pkg.sv
// Package with shared types, constants, the size saturation function and the axis mapping function of the grid slicer.
`timescale 1ns / 1ps
`default_nettype none

package bgts_pkg;

   localparam int FRAC_BITS = 12;
   localparam int MAP_SHIFT = 15 - FRAC_BITS;
   localparam int BANK_ADDR_W = 12;
   localparam int BANK_DEPTH = 1 << BANK_ADDR_W;
   localparam int PROD1_W = 28;
   localparam int WXY_W = 25;
   localparam int ACC_W = 52;
   localparam int ROUND_SHIFT = 3 * FRAC_BITS;

   localparam logic [12:0] ONE_FX = 13'd4096;
   localparam logic [4:0] GRID_W_MAX = 5'd16;
   localparam logic [4:0] GRID_H_MAX = 5'd16;
   localparam logic [4:0] GRID_D_MAX = 5'd8;
   localparam logic [4:0] CHANNELS_MAX = 5'd16;
   localparam logic [4:0] SIZE_MIN = 5'd2;

   localparam logic [1:0] CSR_GRID_WIDTH = 2'd0;
   localparam logic [1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_GRID_DEPTH = 2'd2;
   localparam logic [1:0] CSR_CHANNELS = 2'd3;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_SLICE = 1'b1;

   typedef struct packed {
      logic               func;
      logic [3:0]         cell_x;
      logic [3:0]         cell_y;
      logic [2:0]         cell_z;
      logic [3:0]         cell_channel;
      logic signed [15:0] cell_value;
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_y;
      logic signed [15:0] coord_s;
      logic [3:0]         group;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sliced_value;
      logic [3:0]         out_channel;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  lo;
      logic [11:0] frac;
   } axis_type;

   function automatic logic [4:0] sat_size(input logic [4:0] v, input logic [4:0] lo,
                                           input logic [4:0] hi);
      logic [4:0] r;
      if (v < lo) r = lo;
      else if (v > hi) r = hi;
      else r = v;
      return r;
   endfunction

   // Maps a Q1.14 coordinate to a clamped grid position with FRAC_BITS fraction bits.
   function automatic axis_type map_axis(input logic signed [15:0] c, input logic [4:0] size);
      logic signed [24:0] t;
      logic [19:0]        top;
      logic [19:0]        tc;
      logic [16:0]        fx;
      axis_type           r;
      t = ($signed({{9{c[15]}}, c}) + 25'sd16384) * $signed({20'd0, size}) - 25'sd16384;
      top = {size - 5'd1, 15'd0};
      if (t < 25'sd0) tc = 20'd0;
      else if (t > $signed({5'd0, top})) tc = top;
      else tc = t[19:0];
      fx = 17'(tc >> MAP_SHIFT);
      r.lo = fx[FRAC_BITS +: 4];
      r.frac = fx[FRAC_BITS-1:0];
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: src/bilateral_grid_trilinear_slice.sv
// Top level of the bilateral grid slicer: banked grid store and trilinear pipeline.
// A slice request passes the registered stages 1, 2, issue, bank read, first product, second
// product, pair sum and result before its first result is on the result ports, then one
// result per cycle; busy stays high until the channel issue counter, which reads the eight
// corner banks once per channel, has issued the last channel (at most channels_per_group).
// A load request can follow every cycle while busy is low. Results cannot be stalled.
// After reset a clearing pass zeroes the eight 4096-entry banks, one row per cycle,
// holding busy high until the last row is written; configuration writes are taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module bilateral_grid_trilinear_slice (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire bgts_pkg::req_type req_item,
   output logic                  rsp_valid,
   output bgts_pkg::rsp_type     rsp_item,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [4:0]       csr_data
);

   logic [4:0] width_ff, height_ff, cpg_ff;
   logic [3:0] depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 5'd16;
         height_ff <= 5'd16;
         depth_ff <= 4'd8;
         cpg_ff <= 5'd12;
      end else if (csr_we) begin
         case (csr_index)
            bgts_pkg::CSR_GRID_WIDTH: width_ff <= csr_data;
            bgts_pkg::CSR_GRID_HEIGHT: height_ff <= csr_data;
            bgts_pkg::CSR_GRID_DEPTH: depth_ff <= csr_data[3:0];
            bgts_pkg::CSR_CHANNELS: cpg_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Clearing pass after reset.
   logic        clr_ff, clr_in;
   logic [bgts_pkg::BANK_ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;

   always_comb begin
      clr_in = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == bgts_pkg::BANK_ADDR_W'(bgts_pkg::BANK_DEPTH - 1)) clr_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         clr_ff <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   logic accept;
   logic s1_v_ff, s2_v_ff, iss_ff;
   assign busy = clr_ff | s1_v_ff | s2_v_ff | iss_ff;
   assign accept = start & ~busy;

   // Stage 1: request fields and saturated sizes.
   logic signed [15:0] s1_cx_ff, s1_cy_ff, s1_cs_ff;
   logic [4:0]         s1_w_ff, s1_h_ff, s1_d_ff;
   logic [7:0]         s1_first_ff;
   logic [4:0]         s1_cpg_ff;
   logic [4:0]         cpg_sat;

   assign cpg_sat = bgts_pkg::sat_size(cpg_ff, 5'd1, bgts_pkg::CHANNELS_MAX);

   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else s1_v_ff <= accept & (req_item.func == bgts_pkg::FUNC_SLICE);
      s1_cx_ff <= req_item.coord_x;
      s1_cy_ff <= req_item.coord_y;
      s1_cs_ff <= req_item.coord_s;
      s1_w_ff <= bgts_pkg::sat_size(width_ff, bgts_pkg::SIZE_MIN, bgts_pkg::GRID_W_MAX);
      s1_h_ff <= bgts_pkg::sat_size(height_ff, bgts_pkg::SIZE_MIN, bgts_pkg::GRID_H_MAX);
      s1_d_ff <= bgts_pkg::sat_size({1'b0, depth_ff}, bgts_pkg::SIZE_MIN,
                                    bgts_pkg::GRID_D_MAX);
      s1_first_ff <= 8'({4'd0, req_item.group} * {3'd0, cpg_sat});
      s1_cpg_ff <= cpg_sat;
   end

   // Stage 2: mapped axes and channel range.
   bgts_pkg::axis_type s2_ax_ff, s2_ay_ff, s2_az_ff;
   logic [7:0]         s2_first_ff;
   logic [4:0]         s2_end_ff;
   logic [8:0]         end_sum;

   assign end_sum = {1'b0, s1_first_ff} + {4'd0, s1_cpg_ff};

   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else s2_v_ff <= s1_v_ff;
      s2_ax_ff <= bgts_pkg::map_axis(s1_cx_ff, s1_w_ff);
      s2_ay_ff <= bgts_pkg::map_axis(s1_cy_ff, s1_h_ff);
      s2_az_ff <= bgts_pkg::map_axis(s1_cs_ff, s1_d_ff);
      s2_first_ff <= s1_first_ff;
      s2_end_ff <= (end_sum > {4'd0, bgts_pkg::CHANNELS_MAX}) ?
                   bgts_pkg::CHANNELS_MAX : end_sum[4:0];
   end

   // Issue stage: weights and the channel counter.
   logic [12:0] wx0, wy0, wz0;
   assign wx0 = bgts_pkg::ONE_FX - {1'b0, s2_ax_ff.frac};
   assign wy0 = bgts_pkg::ONE_FX - {1'b0, s2_ay_ff.frac};
   assign wz0 = bgts_pkg::ONE_FX - {1'b0, s2_az_ff.frac};

   logic [bgts_pkg::WXY_W-1:0] iss_wxy_ff [4];
   logic [12:0] iss_wz_ff [2];
   logic [3:0]  iss_x0_ff, iss_y0_ff;
   logic [2:0]  iss_z0_ff;
   logic [4:0]  iss_ch_ff, iss_end_ff;
   logic        iss_last;

   assign iss_last = (iss_ch_ff + 5'd1) == iss_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff <= 1'b0;
      end else if (s2_v_ff) begin
         iss_ff <= s2_first_ff < {3'd0, bgts_pkg::CHANNELS_MAX};
      end else if (iss_ff && iss_last) begin
         iss_ff <= 1'b0;
      end
      if (s2_v_ff) begin
         iss_wxy_ff[0] <= bgts_pkg::WXY_W'(wx0 * wy0);
         iss_wxy_ff[1] <= bgts_pkg::WXY_W'({1'b0, s2_ax_ff.frac} * wy0);
         iss_wxy_ff[2] <= bgts_pkg::WXY_W'(wx0 * {1'b0, s2_ay_ff.frac});
         iss_wxy_ff[3] <= bgts_pkg::WXY_W'({1'b0, s2_ax_ff.frac} * {1'b0, s2_ay_ff.frac});
         iss_wz_ff[0] <= wz0;
         iss_wz_ff[1] <= {1'b0, s2_az_ff.frac};
         iss_x0_ff <= s2_ax_ff.lo;
         iss_y0_ff <= s2_ay_ff.lo;
         iss_z0_ff <= s2_az_ff.lo[2:0];
         iss_ch_ff <= s2_first_ff[4:0];
         iss_end_ff <= s2_end_ff;
      end else if (iss_ff) begin
         iss_ch_ff <= iss_ch_ff + 5'd1;
      end
   end

   // Grid store: eight banks split by the parity of x, y and z, so that the
   // eight corners of a cell always fall into different banks. An upper
   // corner past the last cell reads a wrapped or out-of-grid cell whose weight is zero.
   logic [15:0] rd_ff [8];
   logic [2:0]  load_bank;
   logic [bgts_pkg::BANK_ADDR_W-1:0] load_addr;
   logic        load_we;

   assign load_bank = {req_item.cell_z[0], req_item.cell_y[0], req_item.cell_x[0]};
   assign load_addr = {req_item.cell_channel, req_item.cell_z[2:1], req_item.cell_y[3:1],
                       req_item.cell_x[3:1]};
   assign load_we = accept & (req_item.func == bgts_pkg::FUNC_LOAD);

   for (genvar b = 0; b < 8; b++) begin : g_bank
      logic [15:0] mem [bgts_pkg::BANK_DEPTH];
      logic [3:0]  xa, ya;
      logic [2:0]  za;
      logic [bgts_pkg::BANK_ADDR_W-1:0] raddr, waddr;
      logic        we;
      logic [15:0] wdata;

      assign xa = (iss_x0_ff[0] == 1'(b)) ? iss_x0_ff : iss_x0_ff + 4'd1;
      assign ya = (iss_y0_ff[0] == 1'(b >> 1)) ? iss_y0_ff : iss_y0_ff + 4'd1;
      assign za = (iss_z0_ff[0] == 1'(b >> 2)) ? iss_z0_ff : iss_z0_ff + 3'd1;
      assign raddr = {iss_ch_ff[3:0], za[2:1], ya[3:1], xa[3:1]};
      assign we = clr_ff | (load_we & (load_bank == 3'(b)));
      assign waddr = clr_ff ? clr_cnt_ff : load_addr;
      assign wdata = clr_ff ? 16'd0 : req_item.cell_value;

      always_ff @(posedge clock) begin
         if (we) mem[waddr] <= wdata;
         rd_ff[b] <= mem[raddr];
      end
   end

   // Read stage side data.
   logic        rd_v_ff, rd_last_ff;
   logic [3:0]  rd_ch_ff;
   logic [2:0]  rd_par_ff;
   logic [bgts_pkg::WXY_W-1:0] rd_wxy_ff [4];
   logic [12:0] rd_wz_ff [2];

   always_ff @(posedge clock) begin
      if (reset) rd_v_ff <= 1'b0;
      else rd_v_ff <= iss_ff;
      rd_last_ff <= iss_last;
      rd_ch_ff <= iss_ch_ff[3:0];
      rd_par_ff <= {iss_z0_ff[0], iss_y0_ff[0], iss_x0_ff[0]};
      rd_wxy_ff <= iss_wxy_ff;
      rd_wz_ff <= iss_wz_ff;
   end

   // First product: offset-binary corner value times the z weight.
   logic        p1_v_ff, p1_last_ff;
   logic [3:0]  p1_ch_ff;
   logic [bgts_pkg::PROD1_W-1:0] p1_ff [8];
   logic [bgts_pkg::WXY_W-1:0]   p1_wxy_ff [4];

   always_ff @(posedge clock) begin
      if (reset) p1_v_ff <= 1'b0;
      else p1_v_ff <= rd_v_ff;
      p1_last_ff <= rd_last_ff;
      p1_ch_ff <= rd_ch_ff;
      p1_wxy_ff <= rd_wxy_ff;
      for (int k = 0; k < 8; k++) begin
         p1_ff[k] <= bgts_pkg::PROD1_W'((rd_ff[3'(k) ^ rd_par_ff] ^ 16'h8000) *
                                         rd_wz_ff[k >> 2]);
      end
   end

   // Second product: times the xy weight.
   logic        p2_v_ff, p2_last_ff;
   logic [3:0]  p2_ch_ff;
   logic [bgts_pkg::ACC_W-1:0] p2_ff [8];

   always_ff @(posedge clock) begin
      if (reset) p2_v_ff <= 1'b0;
      else p2_v_ff <= p1_v_ff;
      p2_last_ff <= p1_last_ff;
      p2_ch_ff <= p1_ch_ff;
      for (int k = 0; k < 8; k++) begin
         p2_ff[k] <= bgts_pkg::ACC_W'(p1_ff[k] * p1_wxy_ff[k & 3]);
      end
   end

   // Pair sums.
   logic        ps_v_ff, ps_last_ff;
   logic [3:0]  ps_ch_ff;
   logic [bgts_pkg::ACC_W-1:0] ps_ff [4];

   always_ff @(posedge clock) begin
      if (reset) ps_v_ff <= 1'b0;
      else ps_v_ff <= p2_v_ff;
      ps_last_ff <= p2_last_ff;
      ps_ch_ff <= p2_ch_ff;
      for (int k = 0; k < 4; k++) begin
         ps_ff[k] <= p2_ff[2*k] + p2_ff[2*k+1];
      end
   end

   // Final sum, rounding and removal of the offset-binary bias.
   logic [bgts_pkg::ACC_W-1:0] acc;
   assign acc = ps_ff[0] + ps_ff[1] + ps_ff[2] + ps_ff[3] +
                (bgts_pkg::ACC_W'(1) << (bgts_pkg::ROUND_SHIFT - 1));

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= ps_v_ff;
      rsp_item.sliced_value <= acc[bgts_pkg::ROUND_SHIFT +: 16] ^ 16'h8000;
      rsp_item.out_channel <= ps_ch_ff;
      rsp_item.last <= ps_last_ff;
   end

   a_clear_busy: assert property (@(posedge clock) disable iff (reset) clr_ff |-> busy)
      else $error("clearing pass without busy");
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !rsp_valid && !iss_ff)
      else $error("slice activity during clearing pass");
   a_rsp_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last |=> rsp_valid)
      else $error("gap inside a channel run");
   a_issue_after_map: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff |=> s2_v_ff && !iss_ff)
      else $error("mapping stage out of order");

endmodule

`default_nettype wire
